### hw/rtl/rars_pkg.sv
// Shared types and codes for the range add / range sum segment tree.
// Used by range_add_range_sum_tree_unit; no dependencies.
package rars_pkg;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_SUM = 1'b1;

    typedef struct packed {
        logic [31:0] pend;
        logic [31:0] sum;
    } t_node;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTRY,
        S_NODE,
        S_APP_RD,
        S_APP_MUL,
        S_APP_WR,
        S_PAR_WR,
        S_DESCEND,
        S_RET,
        S_BACK,
        S_FIX_RR,
        S_FIX_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        APP_COVER,
        APP_LEFT,
        APP_RIGHT
    } t_app;

endpackage

### hw/rtl/range_add_range_sum_tree_unit.sv
// Range add / range sum over a lazy segment tree, top level.
// Depends on rars_pkg and rars_ram.
//
// One command is taken at a time; the input is not ready while a command walks the tree.
// A small sequencer walks the tree with a frame stack, and every node step goes through
// the single node RAM port and one 32 x 32 multiplier (low word kept). A partly covered
// node also pushes its pending increment down to both children when it is nonzero, and
// an add rebuilds the sum of each partly covered node on the way back. Over 1024 elements
// a command visits up to about 19 partly covered and 20 other nodes. An empty add does not
// walk the tree, and an empty sum hands out zero. After reset and after each length write
// the node RAM is cleared, one entry per cycle, over all 2*MAX_ELEMENTS entries, during
// which no command is taken. A length write is taken only while no command runs. A sum
// result waits in an output register; a later sum can finish only once that register is
// free.
module range_add_range_sum_tree_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data,        // active_length
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,    // range_low[10:0], range_high[21:11], delta[53:22]
    input  logic        i_s_axis_tuser,    // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata     // range_total
);

    localparam int PW    = $clog2(MAX_ELEMENTS);
    localparam int AW    = PW + 1;
    localparam int NODES = 2 * MAX_ELEMENTS;
    localparam int CW    = (PW + 1 > 11) ? PW + 1 : 11;
    localparam int STK   = PW + 1;
    localparam int IW    = $clog2(STK);
    localparam int SPW   = $clog2(STK + 1);
    localparam int RST_LEN = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;

    rars_pkg::t_state r_state, n_state;
    rars_pkg::t_app   r_app, n_app;
    logic [CW-1:0]  r_len, n_len;
    logic [AW-1:0]  r_clr, n_clr;
    logic [PW-1:0]  r_l, n_l, r_r, n_r, r_ql, n_ql, r_qr, n_qr, r_tl, n_tl, r_tr, n_tr;
    logic           r_flag, n_flag, r_cmd, n_cmd;
    logic [31:0]    r_v, n_v, r_tv, n_tv, r_acc, n_acc, r_prod, n_prod;
    logic [31:0]    r_par_sum, n_par_sum, r_lsum, n_lsum, r_out, n_out;
    rars_pkg::t_node r_node, n_node;
    logic [SPW-1:0] r_sp, n_sp;
    logic           r_out_valid, n_out_valid;
    logic [PW-1:0]  r_stk_l [STK];
    logic [PW-1:0]  r_stk_r [STK];
    logic           r_stk_f [STK];

    logic            push_en, push_f;
    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    rars_pkg::t_node ram_wdata, ram_rdata;

    // node addressing: (l+r) | (l != r)
    logic [AW-1:0] cur_s, lc_s, rc_s, tg_s, a_cur, a_lc, a_rc, a_tgt;
    logic [PW-1:0] mid, rlo;
    logic [AW-1:0] span_t;
    logic [31:0]   prod_w;
    logic          cov, disj;
    logic [IW-1:0] top_idx;
    logic [SPW-1:0] sp_m1;

    // input clipping
    logic [10:0]   in_lo, in_hi, lo_c, cfg_v0;
    logic [CW-1:0] hi_c, lo_w, lo_m1, hi_m1, cfg_cl;
    logic          in_empty;

    always_comb begin
        cur_s  = AW'(r_l) + AW'(r_r);
        mid    = cur_s[AW-1:1];
        rlo    = mid + PW'(1);
        lc_s   = AW'(r_l) + AW'(mid);
        rc_s   = AW'(rlo) + AW'(r_r);
        tg_s   = AW'(r_tl) + AW'(r_tr);
        a_cur  = cur_s | AW'(r_l != r_r);
        a_lc   = lc_s | AW'(r_l != mid);
        a_rc   = rc_s | AW'(rlo != r_r);
        a_tgt  = tg_s | AW'(r_tl != r_tr);
        span_t = AW'(r_tr) - AW'(r_tl) + AW'(1);
        prod_w = r_tv * 32'(span_t);
        cov    = (r_ql <= r_l) && (r_r <= r_qr);
        disj   = (r_qr < r_l) || (r_r < r_ql);
        sp_m1  = r_sp - SPW'(1);
        top_idx = sp_m1[IW-1:0];

        in_lo    = i_s_axis_tdata[10:0];
        in_hi    = i_s_axis_tdata[21:11];
        lo_c     = (in_lo == 11'd0) ? 11'd1 : in_lo;
        lo_w     = CW'(lo_c);
        hi_c     = (CW'(in_hi) > r_len) ? r_len : CW'(in_hi);
        in_empty = lo_w > hi_c;
        lo_m1    = lo_w - CW'(1);
        hi_m1    = hi_c - CW'(1);
        cfg_v0   = (i_cfg_data == 11'd0) ? 11'd1 : i_cfg_data;
        cfg_cl   = (CW'(cfg_v0) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(cfg_v0);
    end

    assign o_cfg_ready     = (r_state == rars_pkg::S_IDLE);
    assign o_s_axis_tready = (r_state == rars_pkg::S_IDLE) && !i_cfg_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    rars_ram #(
        .WIDTH (64),
        .DEPTH (NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;   n_app = r_app;     n_len = r_len;     n_clr = r_clr;
        n_l = r_l;           n_r = r_r;         n_ql = r_ql;       n_qr = r_qr;
        n_tl = r_tl;         n_tr = r_tr;       n_flag = r_flag;   n_cmd = r_cmd;
        n_v = r_v;           n_tv = r_tv;       n_acc = r_acc;     n_prod = r_prod;
        n_par_sum = r_par_sum; n_lsum = r_lsum; n_out = r_out;     n_node = r_node;
        n_sp = r_sp;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        push_en   = 1'b0;
        push_f    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = a_cur;
        ram_wdata = '0;

        case (r_state)
            rars_pkg::S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(NODES - 1)) begin
                    n_state = rars_pkg::S_IDLE;
                end
            end
            rars_pkg::S_IDLE: begin
                if (o_s_axis_tready && i_s_axis_tvalid) begin
                    n_cmd = i_s_axis_tuser;
                    n_v   = i_s_axis_tdata[53:22];
                    n_ql  = lo_m1[PW-1:0];
                    n_qr  = hi_m1[PW-1:0];
                    n_acc = '0;
                    n_l   = '0;
                    n_r   = PW'(r_len - CW'(1));
                    n_sp  = '0;
                    if (in_empty) begin
                        n_state = (i_s_axis_tuser == rars_pkg::CMD_SUM) ?
                                  rars_pkg::S_DONE : rars_pkg::S_IDLE;
                    end else begin
                        n_state = rars_pkg::S_ENTRY;
                    end
                end
            end
            rars_pkg::S_ENTRY: begin
                n_tl = r_l;
                n_tr = r_r;
                n_tv = r_v;
                n_state = disj ? rars_pkg::S_RET : rars_pkg::S_NODE;
            end
            rars_pkg::S_NODE: begin
                if (cov) begin
                    if (r_cmd == rars_pkg::CMD_SUM) begin
                        n_acc   = r_acc + ram_rdata.sum;
                        n_state = rars_pkg::S_RET;
                    end else begin
                        n_node  = ram_rdata;
                        n_prod  = prod_w;
                        n_app   = rars_pkg::APP_COVER;
                        n_state = rars_pkg::S_APP_WR;
                    end
                end else begin
                    n_par_sum = ram_rdata.sum;
                    if (ram_rdata.pend == 32'd0) begin
                        n_state = rars_pkg::S_DESCEND;
                    end else begin
                        n_tv    = ram_rdata.pend;
                        n_tl    = r_l;
                        n_tr    = mid;
                        n_app   = rars_pkg::APP_LEFT;
                        n_state = rars_pkg::S_APP_RD;
                    end
                end
            end
            rars_pkg::S_APP_RD: begin
                ram_addr = a_tgt;
                n_state  = rars_pkg::S_APP_MUL;
            end
            rars_pkg::S_APP_MUL: begin
                n_node  = ram_rdata;
                n_prod  = prod_w;
                n_state = rars_pkg::S_APP_WR;
            end
            rars_pkg::S_APP_WR: begin
                ram_we         = 1'b1;
                ram_addr       = a_tgt;
                ram_wdata.pend = r_node.pend + ((r_tl != r_tr) ? r_tv : 32'd0);
                ram_wdata.sum  = r_node.sum + r_prod;
                case (r_app)
                    rars_pkg::APP_COVER: n_state = rars_pkg::S_RET;
                    rars_pkg::APP_LEFT: begin
                        n_tl    = rlo;
                        n_tr    = r_r;
                        n_app   = rars_pkg::APP_RIGHT;
                        n_state = rars_pkg::S_APP_RD;
                    end
                    default: n_state = rars_pkg::S_PAR_WR;
                endcase
            end
            rars_pkg::S_PAR_WR: begin
                ram_we        = 1'b1;
                ram_wdata.sum = r_par_sum;
                n_state       = rars_pkg::S_DESCEND;
            end
            rars_pkg::S_DESCEND: begin
                push_en = 1'b1;
                n_sp    = r_sp + SPW'(1);
                n_r     = mid;
                n_state = rars_pkg::S_ENTRY;
            end
            rars_pkg::S_RET: begin
                if (r_sp == '0) begin
                    n_state = (r_cmd == rars_pkg::CMD_SUM) ? rars_pkg::S_DONE : rars_pkg::S_IDLE;
                end else begin
                    n_l     = r_stk_l[top_idx];
                    n_r     = r_stk_r[top_idx];
                    n_flag  = r_stk_f[top_idx];
                    n_sp    = sp_m1;
                    n_state = rars_pkg::S_BACK;
                end
            end
            rars_pkg::S_BACK: begin
                if (!r_flag) begin
                    push_en = 1'b1;
                    push_f  = 1'b1;
                    n_sp    = r_sp + SPW'(1);
                    n_l     = rlo;
                    n_state = rars_pkg::S_ENTRY;
                end else if (r_cmd == rars_pkg::CMD_ADD) begin
                    ram_addr = a_lc;
                    n_state  = rars_pkg::S_FIX_RR;
                end else begin
                    n_state = rars_pkg::S_RET;
                end
            end
            rars_pkg::S_FIX_RR: begin
                n_lsum   = ram_rdata.sum;
                ram_addr = a_rc;
                n_state  = rars_pkg::S_FIX_WR;
            end
            rars_pkg::S_FIX_WR: begin
                ram_we        = 1'b1;
                ram_wdata.sum = r_lsum + ram_rdata.sum;
                n_state       = rars_pkg::S_RET;
            end
            rars_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_acc;
                    n_state     = rars_pkg::S_IDLE;
                end
            end
            default: n_state = rars_pkg::S_IDLE;
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            n_len   = cfg_cl;
            n_clr   = '0;
            n_sp    = '0;
            n_state = rars_pkg::S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rars_pkg::S_CLEAR;
            r_len       <= CW'(RST_LEN);
            r_clr       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_clr       <= n_clr;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_app <= n_app;     r_l <= n_l;       r_r <= n_r;       r_ql <= n_ql;
        r_qr <= n_qr;       r_tl <= n_tl;     r_tr <= n_tr;     r_flag <= n_flag;
        r_cmd <= n_cmd;     r_v <= n_v;       r_tv <= n_tv;     r_acc <= n_acc;
        r_prod <= n_prod;   r_par_sum <= n_par_sum;  r_lsum <= n_lsum;
        r_out <= n_out;     r_node <= n_node;
        if (push_en) begin
            r_stk_l[r_sp[IW-1:0]] <= r_l;
            r_stk_r[r_sp[IW-1:0]] <= r_r;
            r_stk_f[r_sp[IW-1:0]] <= push_f;
        end
    end

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STK))
        else $error("frame stack overflow");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rars_pkg::S_IDLE) |-> (r_sp == '0))
        else $error("frames left on stack at idle");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != rars_pkg::S_CLEAR) |-> ((CW + 1)'(ram_addr) < {r_len, 1'b0}))
        else $error("node write outside active tree");

endmodule

### hw/rtl/rars_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rars_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
